>>> sv/wavpcm_pkg.sv
// Package for the WAV PCM stream parser: result kinds, error codes, parse
// phases and the table of expected header bytes.
// No dependencies.
package wavpcm_pkg;

  localparam int unsigned HeaderBytes = 44;
  localparam int unsigned PosW        = 6;

  typedef logic [PosW-1:0] hdr_pos_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_INFO   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_RIFF      = 3'd0,
    ERR_WAVE      = 3'd1,
    ERR_FMT_TAG   = 3'd2,
    ERR_FMT_SIZE  = 3'd3,
    ERR_FORMAT_ID = 3'd4,
    ERR_NOT_MONO  = 3'd5,
    ERR_DATA_TAG  = 3'd6,
    ERR_BIT_DEPTH = 3'd7
  } err_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DATA   = 3'b010,
    PH_IDLE   = 3'b100
  } phase_e;

  // Header byte positions that carry captured fields.
  localparam hdr_pos_t PosRateFirst  = hdr_pos_t'(24);
  localparam hdr_pos_t PosRateLast   = hdr_pos_t'(27);
  localparam hdr_pos_t PosDepth      = hdr_pos_t'(34);
  localparam hdr_pos_t PosLengthFirst = hdr_pos_t'(40);
  localparam hdr_pos_t PosLengthLast = hdr_pos_t'(HeaderBytes - 1);

  // Reciprocal of three for a 32-bit dividend: x / 3 = (x * Recip3) >> 33.
  localparam logic [31:0] Recip3 = 32'hAAAA_AAAB;
  localparam int unsigned Recip3Shift = 33;

  typedef struct packed {
    logic       check;
    logic [7:0] expect_byte;
    err_e       err;
  } hdr_rule_t;

  // Expected byte at each checked header position and the error it raises.
  function automatic hdr_rule_t hdr_rule(hdr_pos_t pos);
    hdr_rule_t r;
    r.check       = 1'b1;
    r.expect_byte = 8'h00;
    r.err         = ERR_RIFF;
    case (pos)
      6'd0:  r.expect_byte = 8'h52;  // 'R'
      6'd1:  r.expect_byte = 8'h49;  // 'I'
      6'd2:  r.expect_byte = 8'h46;  // 'F'
      6'd3:  r.expect_byte = 8'h46;  // 'F'
      6'd8:  begin r.expect_byte = 8'h57; r.err = ERR_WAVE; end  // 'W'
      6'd9:  begin r.expect_byte = 8'h41; r.err = ERR_WAVE; end  // 'A'
      6'd10: begin r.expect_byte = 8'h56; r.err = ERR_WAVE; end  // 'V'
      6'd11: begin r.expect_byte = 8'h45; r.err = ERR_WAVE; end  // 'E'
      6'd12: begin r.expect_byte = 8'h66; r.err = ERR_FMT_TAG; end  // 'f'
      6'd13: begin r.expect_byte = 8'h6D; r.err = ERR_FMT_TAG; end  // 'm'
      6'd14: begin r.expect_byte = 8'h74; r.err = ERR_FMT_TAG; end  // 't'
      6'd15: begin r.expect_byte = 8'h20; r.err = ERR_FMT_TAG; end  // ' '
      6'd16: begin r.expect_byte = 8'h10; r.err = ERR_FMT_SIZE; end
      6'd17, 6'd18, 6'd19: r.err = ERR_FMT_SIZE;
      6'd20: begin r.expect_byte = 8'h01; r.err = ERR_FORMAT_ID; end
      6'd21: r.err = ERR_FORMAT_ID;
      6'd22: begin r.expect_byte = 8'h01; r.err = ERR_NOT_MONO; end
      6'd23: r.err = ERR_NOT_MONO;
      6'd36: begin r.expect_byte = 8'h64; r.err = ERR_DATA_TAG; end  // 'd'
      6'd37: begin r.expect_byte = 8'h61; r.err = ERR_DATA_TAG; end  // 'a'
      6'd38: begin r.expect_byte = 8'h74; r.err = ERR_DATA_TAG; end  // 't'
      6'd39: begin r.expect_byte = 8'h61; r.err = ERR_DATA_TAG; end  // 'a'
      default: r.check = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/wavpcm_if.sv
// Stream interfaces of the WAV PCM stream parser: the byte request channel
// and the result channel. Depends on wavpcm_pkg.
interface wavpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface wavpcm_out_if import wavpcm_pkg::*; ;
  logic               valid;
  logic               ready;
  kind_e              kind;
  logic signed [31:0] sample;
  logic [31:0]        sample_rate;
  logic [7:0]         bits_per_sample;
  logic [31:0]        sample_count;
  err_e               error_code;
  logic               last;

  modport source (output valid, output kind, output sample, output sample_rate,
                  output bits_per_sample, output sample_count, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input sample, input sample_rate,
                  input bits_per_sample, input sample_count, input error_code,
                  input last, output ready);
endinterface

>>> sv/wav_pcm_stream_parser.sv
// Byte-serial RIFF/WAVE PCM parser. A result is registered and appears on the
// output in the cycle after the byte that causes it is accepted. Throughput: one
// byte per cycle; a request is refused only while a result waits untaken in the
// output register. Reset (rst_ni low, asynchronous) empties the output
// register and returns the parser to the start of a header.
module wav_pcm_stream_parser import wavpcm_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  wavpcm_in_if.sink      in_i,
  wavpcm_out_if.source   out_o
);

  // Parser state. Everything is restarted by a request with start_req set,
  // so a new file may begin at any byte, also in the middle of a sample.
  phase_e      phase_q, phase_d;
  hdr_pos_t    pos_q, pos_d;
  logic [31:0] rate_q, rate_d;
  logic [7:0]  depth_q, depth_d;
  // Data bytes still to come. It holds the raw data length, not a rounded
  // one: a sample is the last when fewer than one sample's bytes remain.
  logic [31:0] remain_q, remain_d;
  logic [31:0] asm_q, asm_d;
  logic [1:0]  bis_q, bis_d;

  // Output register.
  logic               out_valid_q;
  kind_e              kind_d, kind_q;
  logic signed [31:0] sample_d, sample_q;
  logic [31:0]        orate_d, orate_q;
  logic [7:0]         obits_d, obits_q;
  logic [31:0]        ocount_d, ocount_q;
  err_e               oerr_d, oerr_q;
  logic               olast_d, olast_q;
  logic               emit;

  logic accept;

  // Effective state after an optional restart.
  phase_e      ph_e;
  hdr_pos_t    pos_e;
  logic [31:0] rate_e, remain_e, asm_e;
  logic [7:0]  depth_e;
  logic [1:0]  bis_e;

  hdr_rule_t   rule;
  logic [31:0] length_full;
  logic [2:0]  nbytes;
  logic        depth_ok;
  logic [63:0] prod3;
  logic [31:0] count;
  logic [31:0] asm_next, remain_next;
  logic [2:0]  nb_data;

  // The input side only waits when a result sits in the output register
  // and the downstream side is not taking it in this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign rule        = hdr_rule(pos_e);
  assign length_full = {in_i.data_byte, remain_e[31:8]};
  assign nbytes      = depth_e[5:3];
  assign depth_ok    = (depth_e == 8'd8) || (depth_e == 8'd16) ||
                       (depth_e == 8'd24) || (depth_e == 8'd32);
  // Division by three through a constant reciprocal; only the header's
  // closing byte uses it.
  assign prod3       = {32'd0, length_full} * {32'd0, Recip3};
  assign nb_data     = depth_q[5:3];
  assign asm_next    = {in_i.data_byte, asm_e[31:8]};
  assign remain_next = remain_e - 32'd1;

  always_comb begin
    case (nbytes)
      3'd1:    count = length_full;
      3'd2:    count = {1'b0, length_full[31:1]};
      3'd3:    count = {1'b0, prod3[63:Recip3Shift]};
      3'd4:    count = {2'b00, length_full[31:2]};
      default: count = 32'd0;
    endcase
  end

  always_comb begin
    if (in_i.start_req) begin
      ph_e     = PH_HEADER;
      pos_e    = '0;
      rate_e   = '0;
      depth_e  = '0;
      remain_e = '0;
      asm_e    = '0;
      bis_e    = '0;
    end else begin
      ph_e     = phase_q;
      pos_e    = pos_q;
      rate_e   = rate_q;
      depth_e  = depth_q;
      remain_e = remain_q;
      asm_e    = asm_q;
      bis_e    = bis_q;
    end

    phase_d  = ph_e;
    pos_d    = pos_e;
    rate_d   = rate_e;
    depth_d  = depth_e;
    remain_d = remain_e;
    asm_d    = asm_e;
    bis_d    = bis_e;

    emit     = 1'b0;
    kind_d   = KIND_SAMPLE;
    sample_d = '0;
    orate_d  = '0;
    obits_d  = '0;
    ocount_d = '0;
    oerr_d   = ERR_RIFF;
    olast_d  = 1'b0;

    case (ph_e)
      PH_HEADER: begin
        if (rule.check && (in_i.data_byte != rule.expect_byte)) begin
          // First header byte that differs ends the parse with its code.
          phase_d = PH_IDLE;
          emit    = 1'b1;
          kind_d  = KIND_ERROR;
          oerr_d  = rule.err;
        end else begin
          if ((pos_e >= PosRateFirst) && (pos_e <= PosRateLast)) begin
            rate_d = {in_i.data_byte, rate_e[31:8]};
          end
          if (pos_e == PosDepth) begin
            depth_d = in_i.data_byte;
          end
          if (pos_e >= PosLengthFirst) begin
            remain_d = length_full;
          end
          pos_d = pos_e + hdr_pos_t'(1);
          if (pos_e == PosLengthLast) begin
            emit = 1'b1;
            if (!depth_ok) begin
              phase_d = PH_IDLE;
              kind_d  = KIND_ERROR;
              oerr_d  = ERR_BIT_DEPTH;
            end else begin
              // An empty data chunk is reported and then nothing follows.
              phase_d  = (count == 32'd0) ? PH_IDLE : PH_DATA;
              asm_d    = '0;
              bis_d    = '0;
              kind_d   = KIND_INFO;
              orate_d  = rate_e;
              obits_d  = depth_e;
              ocount_d = count;
            end
          end
        end
      end
      PH_DATA: begin
        // Little-endian bytes enter at the top, so a finished sample is
        // already left-aligned as Q1.31 with zero low bits.
        asm_d    = asm_next;
        remain_d = remain_next;
        if ({1'b0, bis_e} == (nb_data - 3'd1)) begin
          emit     = 1'b1;
          kind_d   = KIND_SAMPLE;
          sample_d = asm_next;
          olast_d  = (remain_next < {29'd0, nb_data});
          asm_d    = '0;
          bis_d    = '0;
          if (remain_next < {29'd0, nb_data}) begin
            phase_d = PH_IDLE;
          end
        end else begin
          bis_d = bis_e + 2'd1;
        end
      end
      PH_IDLE: begin
        // Bytes are dropped until the next start request.
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      rate_q      <= '0;
      depth_q     <= '0;
      remain_q    <= '0;
      asm_q       <= '0;
      bis_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        rate_q      <= rate_d;
        depth_q     <= depth_d;
        remain_q    <= remain_d;
        asm_q       <= asm_d;
        bis_q       <= bis_d;
        out_valid_q <= emit;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q   <= kind_d;
      sample_q <= sample_d;
      orate_q  <= orate_d;
      obits_q  <= obits_d;
      ocount_q <= ocount_d;
      oerr_q   <= oerr_d;
      olast_q  <= olast_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.kind            = kind_q;
  assign out_o.sample          = sample_q;
  assign out_o.sample_rate     = orate_q;
  assign out_o.bits_per_sample = obits_q;
  assign out_o.sample_count    = ocount_q;
  assign out_o.error_code      = oerr_q;
  assign out_o.last            = olast_q;

  // A waiting, untaken result must hold off the input side.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while a result is stalled");

  // A header report only carries a supported bit depth.
  a_info_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == KIND_INFO) |->
      (out_o.bits_per_sample == 8'd8) || (out_o.bits_per_sample == 8'd16) ||
      (out_o.bits_per_sample == 8'd24) || (out_o.bits_per_sample == 8'd32))
    else $error("header report with unsupported bit depth");

  // The end marker belongs to samples only.
  a_last_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |-> (out_o.kind == KIND_SAMPLE))
    else $error("last set on a non-sample result");

  // After the final sample the parser produces nothing until a restart.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit && olast_d |=> !(accept && !in_i.start_req && emit))
    else $error("result after the final sample without a restart");

endmodule

>>> bench/wavpcm_result_check.sv
`timescale 1ns / 1ps
// Result checker for the WAV PCM stream parser. It watches the byte request and
// result streams, predicts every result and compares it field by field.
// Depends on wavpcm_pkg and the interfaces in wavpcm_if.
module wavpcm_result_check import wavpcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  wavpcm_in_if        in_mon,
  wavpcm_out_if       out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] sample;
    logic [31:0]        sample_rate;
    logic [7:0]         bits_per_sample;
    logic [31:0]        sample_count;
    err_e               error_code;
    logic               last;
  } parse_result_t;

  parse_result_t expected_results[$];

  phase_e      parse_phase;
  hdr_pos_t    hdr_index;
  logic [31:0] rate_shift;
  logic [7:0]  depth_byte;
  logic [31:0] data_left;
  logic [31:0] word_shift;
  int unsigned lane;

  int unsigned fail_count = 0;
  int unsigned pending    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  // Expected byte and error code at one header position; zero when unchecked.
  function automatic bit header_rule(input hdr_pos_t pos, output logic [7:0] want,
                                     output err_e code);
    logic [31:0] tag;
    bit          checked;
    checked = 1'b1;
    tag     = '0;
    code    = ERR_RIFF;
    if (pos < 4) begin
      tag = "RIFF";
    end else if (pos < 8) begin
      checked = 1'b0;
    end else if (pos < 12) begin
      tag  = "WAVE";
      code = ERR_WAVE;
    end else if (pos < 16) begin
      tag  = "fmt ";
      code = ERR_FMT_TAG;
    end else if (pos < 20) begin
      tag  = 32'h1000_0000;
      code = ERR_FMT_SIZE;
    end else if (pos < 22) begin
      tag  = 32'h0100_0100;
      code = ERR_FORMAT_ID;
    end else if (pos < 24) begin
      tag  = 32'h0100_0100;
      code = ERR_NOT_MONO;
    end else if (pos >= 36 && pos < 40) begin
      tag  = "data";
      code = ERR_DATA_TAG;
    end else begin
      checked = 1'b0;
    end
    want = tag[8*(3 - pos[1:0]) +: 8];
    return checked;
  endfunction

  function automatic void restart_parse();
    parse_phase = PH_HEADER;
    hdr_index   = '0;
    rate_shift  = '0;
    depth_byte  = '0;
    data_left   = '0;
    word_shift  = '0;
    lane        = 0;
  endfunction

  // Advances the parse by one accepted byte and queues any result it causes.
  function automatic void parse_byte(input logic [7:0] b, input logic start);
    parse_result_t res;
    logic [7:0]    want;
    err_e          code;
    logic [7:0]    nbytes;
    logic [31:0]   count;
    res = '0;
    if (start) restart_parse();
    case (parse_phase)
      PH_HEADER: begin
        if (hdr_index >= HeaderBytes) begin
          parse_phase = PH_IDLE;
        end else if (header_rule(hdr_index, want, code) && b != want) begin
          parse_phase    = PH_IDLE;
          res.kind       = KIND_ERROR;
          res.error_code = code;
          expected_results.push_back(res);
        end else begin
          if (hdr_index >= PosRateFirst && hdr_index <= PosRateLast)
            rate_shift = {b, rate_shift[31:8]};
          if (hdr_index == PosDepth) depth_byte = b;
          if (hdr_index >= PosLengthFirst && hdr_index <= PosLengthLast)
            data_left = {b, data_left[31:8]};
          if (hdr_index == PosLengthLast) begin
            if (!(depth_byte inside {8'd8, 8'd16, 8'd24, 8'd32})) begin
              parse_phase    = PH_IDLE;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BIT_DEPTH;
            end else begin
              nbytes      = depth_byte >> 3;
              count       = data_left / 32'(nbytes);
              data_left   = count * 32'(nbytes);
              word_shift  = '0;
              lane        = 0;
              parse_phase = (count == 0) ? PH_IDLE : PH_DATA;
              res.kind            = KIND_INFO;
              res.sample_rate     = rate_shift;
              res.bits_per_sample = depth_byte;
              res.sample_count    = count;
            end
            expected_results.push_back(res);
          end
          hdr_index = hdr_index + 1'b1;
        end
      end
      PH_DATA: begin
        nbytes = depth_byte >> 3;
        if (nbytes == 0 || nbytes > 4 || data_left == 0) begin
          parse_phase = PH_IDLE;
        end else begin
          word_shift = {b, word_shift[31:8]};
          data_left  = data_left - 1;
          if (lane + 1 >= nbytes) begin
            res.kind   = KIND_SAMPLE;
            res.sample = word_shift;
            res.last   = (data_left == 0);
            lane       = 0;
            word_shift = '0;
            if (res.last) parse_phase = PH_IDLE;
            expected_results.push_back(res);
          end else begin
            lane = lane + 1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%h, got 0x%h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void compare_result();
    parse_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: kind %0d, sample 0x%h", out_mon.kind, out_mon.sample);
      fail_count++;
      return;
    end
    want = expected_results.pop_front();
    check_field("kind", 32'(want.kind), 32'(out_mon.kind));
    check_field("sample", want.sample, out_mon.sample);
    check_field("sample_rate", want.sample_rate, out_mon.sample_rate);
    check_field("bits_per_sample", 32'(want.bits_per_sample), 32'(out_mon.bits_per_sample));
    check_field("sample_count", want.sample_count, out_mon.sample_count);
    check_field("error_code", 32'(want.error_code), 32'(out_mon.error_code));
    check_field("last", 32'(want.last), 32'(out_mon.last));
  endfunction

  // A result leaves no earlier than the cycle after its request, so the
  // result side is compared before the request of the same edge is parsed.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_parse();
      expected_results.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) compare_result();
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        parse_byte(in_mon.data_byte, in_mon.start_req);
    end
    pending = expected_results.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Top of the WAV PCM stream parser testbench: clock, reset, byte stimulus built
// from whole and broken WAV files, random result stalls and the verdict.
// Depends on wavpcm_pkg, wavpcm_if, wav_pcm_stream_parser and wavpcm_result_check.
module testbench;

  localparam int unsigned RandomBytes = 740;
  localparam int unsigned HdrLen      = 44;

  // Tags as they appear in the file, first byte in the top lane.
  localparam logic [31:0] TagRiff = "RIFF";
  localparam logic [31:0] TagWave = "WAVE";
  localparam logic [31:0] TagFmt  = "fmt ";
  localparam logic [31:0] TagData = "data";
  // Little-endian fields: fmt size 16, then format id 1 and one channel.
  localparam logic [31:0] FmtSize    = 32'd16;
  localparam logic [31:0] PcmMono    = 32'h0001_0001;

  // First byte of every checked header group, one per byte-mismatch error.
  localparam int FlawAt [7] = '{0, 8, 12, 16, 20, 22, 36};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // While set, neither the byte source nor the result sink idles.
  bit steady = 1'b0;

  // Requests accepted so far, apart from those sent through send_ignored.
  int unsigned bytes_sent = 0;

  int unsigned fail_count;
  int unsigned pending;

  always #4 clk_i = ~clk_i;

  wavpcm_in_if  req_ch ();
  wavpcm_out_if res_ch ();

  wav_pcm_stream_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  wavpcm_result_check result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (req_ch),
    .out_mon      (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Idle length for either side: mostly none, often short, now and
  // then a long stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A header position inside one of the checked groups.
  function automatic int pick_flaw_pos();
    int unsigned r;
    r = $urandom_range(0, 23);
    if (r < 4) return r;
    if (r < 20) return r + 4;
    return r + 16;
  endfunction

  // Offers one byte request and returns at the falling edge after it was
  // accepted. Inputs only ever change at falling edges. During an idle gap
  // the payload carries junk so that nothing relies on it while valid is low.
  task automatic send_byte(input logic [7:0] value, input logic restart);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'($urandom);
      req_ch.start_req <= 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.data_byte <= value;
    req_ch.start_req <= restart;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Bytes the parser is expected to drop while idle; they do not count.
  task automatic send_ignored(input int unsigned k);
    repeat (k) send_byte(8'($urandom), 1'b0);
    bytes_sent -= k;
  endtask

  task automatic send_data(input int unsigned k);
    repeat (k) send_byte(8'($urandom), 1'b0);
  endtask

  // Sends the first upto bytes of a 44-byte header. Unchecked bytes (file
  // size, byte rate, block align, the high byte of the depth) are random.
  // A flaw position flips bits of one checked byte so that it must mismatch.
  task automatic send_header(input logic [7:0] depth, input logic [31:0] rate,
                             input logic [31:0] length, input int flaw_pos,
                             input int unsigned upto);
    logic [7:0]  hdr [HdrLen];
    int unsigned i;
    for (i = 0; i < HdrLen; i++) hdr[i] = 8'($urandom);
    for (i = 0; i < 4; i++) begin
      hdr[i]      = TagRiff[8*(3-i) +: 8];
      hdr[8 + i]  = TagWave[8*(3-i) +: 8];
      hdr[12 + i] = TagFmt[8*(3-i) +: 8];
      hdr[16 + i] = FmtSize[8*i +: 8];
      hdr[20 + i] = PcmMono[8*i +: 8];
      hdr[24 + i] = rate[8*i +: 8];
      hdr[36 + i] = TagData[8*(3-i) +: 8];
      hdr[40 + i] = length[8*i +: 8];
    end
    hdr[34] = depth;
    if (flaw_pos >= 0) hdr[flaw_pos] = hdr[flaw_pos] ^ 8'($urandom_range(1, 255));
    for (i = 0; i < upto && i < HdrLen; i++) send_byte(hdr[i], i == 0);
  endtask

  // Result sink: ready drops for random stretches unless a steady phase runs.
  initial begin : result_sink
    int unsigned hold;
    hold         = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && !steady && $urandom_range(0, 4) == 0) hold = pick_gap();
      if (hold != 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  depth;
    logic [31:0] rate;
    logic [31:0] length;
    int unsigned n;
    int unsigned pick;
    int          flaw;

    req_ch.valid     = 1'b0;
    req_ch.data_byte = 8'h00;
    req_ch.start_req = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Right after reset the parser already expects header byte zero, so a
    // wrong first byte is a RIFF error even without a start flag. The byte
    // after it falls into idle and must be dropped.
    send_byte(8'h00, 1'b0);
    send_ignored(1);

    // 8-bit samples with the extreme rate: zero, the largest positive, the
    // most negative and minus one. A byte past the data length is dropped.
    send_header(8'd8, 32'hFFFF_FFFF, 32'd4, -1, HdrLen);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_ignored(1);

    // 16-bit with an odd data length: the trailing half sample never emits.
    send_header(8'd16, 32'd44100, 32'd5, -1, HdrLen);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_ignored(1);

    // 24-bit and 32-bit depths at the limits of the sample range.
    send_header(8'd24, 32'd0, 32'd6, -1, HdrLen);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_header(8'd32, 32'd48000, 32'd4, -1, HdrLen);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);

    // A length shorter than one sample reports a count of zero and idles.
    send_header(8'd16, 32'd8000, 32'd1, -1, HdrLen);
    send_ignored(1);

    // Unsupported depths, including zero and all ones.
    send_header(8'd12, 32'd22050, 32'd4, -1, HdrLen);
    send_header(8'd0, 32'd22050, 32'd4, -1, HdrLen);
    send_header(8'd255, 32'd22050, 32'd4, -1, HdrLen);

    // One broken byte in each checked group gives each byte-mismatch error in turn.
    foreach (FlawAt[i]) send_header(8'd8, $urandom, 32'd4, FlawAt[i], FlawAt[i] + 1);

    // A new start in the middle of a sample, an oversized length cut short by
    // a restart, and a restart in the middle of a header.
    send_header(8'd32, 32'd96000, 32'd8, -1, HdrLen);
    send_data(2);
    send_header(8'd8, $urandom, 32'hFFFF_FFFF, -1, HdrLen);
    send_data(6);
    send_header(8'd16, $urandom, 32'd4, -1, 20);
    send_header(8'd16, $urandom, 32'd4, -1, HdrLen);
    send_data(4);

    // Random part: mostly well-formed files with random content and length,
    // the rest broken headers, bad depths, cut headers and plain noise.
    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      steady = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 99);
      depth  = 8'(8 * $urandom_range(1, 4));
      rate   = $urandom;
      if (pick < 70) begin
        n = $urandom_range(0, 48);
        case ($urandom_range(0, 3))
          0: length = n;
          1: length = n + $urandom_range(1, 6);
          2: length = (n > 3) ? n - $urandom_range(1, 3) : n;
          default: length = $urandom;
        endcase
        send_header(depth, rate, length, -1, HdrLen);
        send_data(n);
      end else if (pick < 80) begin
        do depth = 8'($urandom); while (depth inside {8'd8, 8'd16, 8'd24, 8'd32});
        send_header(depth, rate, $urandom_range(0, 64), -1, HdrLen);
        send_ignored($urandom_range(0, 2));
      end else if (pick < 92) begin
        flaw = pick_flaw_pos();
        send_header(depth, rate, $urandom_range(0, 64), flaw, flaw + 1);
        send_ignored($urandom_range(0, 2));
      end else if (pick < 96) begin
        send_header(depth, rate, $urandom_range(0, 64), -1, $urandom_range(1, HdrLen - 1));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
    steady = 1'b0;
    req_ch.valid <= 1'b0;

    // Drain every outstanding result, then leave room for a stray one.
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run, even with every gap and stall long.
  initial begin : watchdog
    #(10_000_000);
    $display("testbench failed");
    $finish;
  end

endmodule

>>> sim.f
sv/wavpcm_pkg.sv
sv/wavpcm_if.sv
sv/wav_pcm_stream_parser.sv
bench/wavpcm_result_check.sv
bench/testbench.sv
